// ----- rtl/ps2mt_pkg.sv -----
`default_nettype none

package ps2mt_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_POS_W  = 16;
  localparam int unsigned DISPLAY_W  = 24;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 64;
  localparam int unsigned M_USED_W   = 2 * OUT_POS_W + 2 + DISPLAY_W;

  localparam int unsigned ST_LEFT    = 0;
  localparam int unsigned ST_RIGHT   = 1;
  localparam int unsigned ST_X_SIGN  = 4;
  localparam int unsigned ST_Y_SIGN  = 5;

  localparam logic [DISPLAY_W-1:0] DISPLAY_BASE = 24'hF00000;
  localparam int unsigned DISP_LEFT_BIT  = 18;
  localparam int unsigned DISP_RIGHT_BIT = 16;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DISPLAY_W-1:0] display_word;
    logic                 right_button;
    logic                 left_button;
    logic [OUT_POS_W-1:0] pos_y;
    logic [OUT_POS_W-1:0] pos_x;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/ps2mt_calc.sv -----
`default_nettype none

module ps2mt_calc #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic [ps2mt_pkg::BYTE_W-1:0]  status_byte,
  input  wire logic [ps2mt_pkg::BYTE_W-1:0]  x_byte,
  input  wire logic [ps2mt_pkg::BYTE_W-1:0]  y_byte,
  input  wire logic [POSITION_WIDTH-1:0]     x_position,
  input  wire logic [POSITION_WIDTH-1:0]     y_position,
  output logic      [POSITION_WIDTH-1:0]     x_sum,
  output logic      [POSITION_WIDTH-1:0]     y_sum,
  output ps2mt_pkg::result_t                 result
);
  import ps2mt_pkg::*;

  localparam int unsigned EXT_W = POSITION_WIDTH - BYTE_W;

  logic [POSITION_WIDTH-1:0]           dx;
  logic [POSITION_WIDTH-1:0]           dy;
  logic [POSITION_WIDTH+OUT_POS_W-1:0] x_wide;
  logic [POSITION_WIDTH+OUT_POS_W-1:0] y_wide;
  logic [DISPLAY_W-1:0]                word;

  always_comb begin
    dx = {{EXT_W{status_byte[ST_X_SIGN]}}, x_byte};
    dy = {{EXT_W{status_byte[ST_Y_SIGN]}}, y_byte};
    x_sum = x_position + dx;
    y_sum = y_position + dy;
    x_wide = {{OUT_POS_W{1'b0}}, x_sum};
    y_wide = {{OUT_POS_W{1'b0}}, y_sum};

    word = DISPLAY_BASE;
    word[DISP_LEFT_BIT]  = status_byte[ST_LEFT];
    word[DISP_RIGHT_BIT] = status_byte[ST_RIGHT];
    word[15:8] = x_sum[7:0];
    word[7:0]  = y_sum[7:0];

    result.pos_x        = x_wide[OUT_POS_W-1:0];
    result.pos_y        = y_wide[OUT_POS_W-1:0];
    result.left_button  = status_byte[ST_LEFT];
    result.right_button = status_byte[ST_RIGHT];
    result.display_word = word;
  end

endmodule

`default_nettype wire

// ----- rtl/ps2_mouse_packet_tracker.sv -----
`default_nettype none

// PS/2 mouse packet tracker.
// Input stream s_*: one received mouse byte per transaction in s_tdata[7:0].
// Bytes are grouped three to a packet (status, X, Y) by count since reset;
// the sync bit is not checked.
// Output stream m_*: one transaction per packet, registered, valid the cycle
// after the third byte is taken. Fields from bit 0: pos_x[15:0],
// pos_y[31:16], left_button[32], right_button[33], display_word[57:34].
// Throughput is one byte per cycle unless a third byte waits on m_tready:
// the packet math is a single add per axis before the output register.
// When both buttons are down, the output shows the summed position and the
// accumulators then clear to zero.
// Reset clears the byte count, held bytes, accumulators and output valid.
// While a result waits on m_tready, status and X bytes are still taken; a
// third byte waits until the output register frees up (same cycle as the
// pending transaction completes is fine).

module ps2_mouse_packet_tracker #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ps2mt_pkg::S_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // pos_x[15:0], pos_y[31:16], left_button[32], right_button[33],
  // display_word[57:34], zero[63:58]
  output logic      [ps2mt_pkg::M_TDATA_W-1:0]  m_tdata
);
  import ps2mt_pkg::*;

  phase_t                    phase;
  phase_t                    phase_next;
  logic [BYTE_W-1:0]         status_byte;
  logic [BYTE_W-1:0]         x_byte;
  logic [POSITION_WIDTH-1:0] x_position;
  logic [POSITION_WIDTH-1:0] y_position;
  logic [POSITION_WIDTH-1:0] x_sum;
  logic [POSITION_WIDTH-1:0] y_sum;
  result_t                   result;
  result_t                   out_reg;
  logic                      s_fire;
  logic                      out_free;
  logic                      emit;
  logic                      both_down;

  ps2mt_calc #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_calc (
    .status_byte (status_byte),
    .x_byte      (x_byte),
    .y_byte      (s_tdata[BYTE_W-1:0]),
    .x_position  (x_position),
    .y_position  (y_position),
    .x_sum       (x_sum),
    .y_sum       (y_sum),
    .result      (result)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (phase != PH_Y) || out_free;
  assign s_fire    = s_tvalid && s_tready;
  assign emit      = s_fire && (phase == PH_Y);
  assign both_down = status_byte[ST_LEFT] && status_byte[ST_RIGHT];

  always_comb begin
    unique case (phase)
      PH_X:    phase_next = PH_Y;
      PH_Y:    phase_next = PH_STATUS;
      default: phase_next = PH_X;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STATUS;
      status_byte <= '0;
      x_byte      <= '0;
      x_position  <= '0;
      y_position  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_fire) begin
        phase <= phase_next;
        unique case (phase)
          PH_X: begin
            x_byte <= s_tdata[BYTE_W-1:0];
          end
          PH_Y: begin
            x_position <= both_down ? '0 : x_sum;
            y_position <= both_down ? '0 : y_sum;
          end
          default: begin
            status_byte <= s_tdata[BYTE_W-1:0];
          end
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_reg};

  a_emit_valid : assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("packet result not presented");

  a_clear_both : assert property (@(posedge clk) disable iff (rst)
    emit && both_down |=> (x_position == '0) && (y_position == '0))
    else $error("position not cleared with both buttons down");

  a_hold_third : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && (phase == PH_Y) |-> !s_tready)
    else $error("third byte taken while output stalled");

  a_phase_step : assert property (@(posedge clk) disable iff (rst)
    s_fire && (phase == PH_X) |=> (phase == PH_Y))
    else $error("byte count skipped");

endmodule

`default_nettype wire

// ----- tb/sv/ps2_packet_monitor.sv -----
module ps2_packet_monitor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [ps2mt_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [ps2mt_pkg::M_TDATA_W-1:0] m_tdata,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   packets_checked,
  output int                                   clears_seen,
  output int                                   wraps_seen
);
  import ps2mt_pkg::*;

  result_t                expected_packets[$];
  result_t                want;
  result_t                got;
  phase_t                 phase_q;
  logic [BYTE_W-1:0]      status_q;
  logic [BYTE_W-1:0]      xmove_q;
  logic [OUT_POS_W-1:0]   x_acc;
  logic [OUT_POS_W-1:0]   y_acc;
  int                     fails;
  int                     checked;
  int                     clears;
  int                     wraps;

  initial begin
    fails = 0;
    checked = 0;
    clears = 0;
    wraps = 0;
    fail_count = 0;
    pending = 0;
    packets_checked = 0;
    clears_seen = 0;
    wraps_seen = 0;
  end

  task automatic compare_field(input string name, input logic [DISPLAY_W-1:0] exp_v,
                               input logic [DISPLAY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic track_byte(input logic [BYTE_W-1:0] b);
    logic [OUT_POS_W-1:0] dx;
    logic [OUT_POS_W-1:0] dy;
    logic [OUT_POS_W-1:0] nx;
    logic [OUT_POS_W-1:0] ny;
    result_t              r;
    case (phase_q)
      PH_X: begin
        xmove_q = b;
        phase_q = PH_Y;
      end
      PH_Y: begin
        dx = {{(OUT_POS_W-BYTE_W){status_q[ST_X_SIGN]}}, xmove_q};
        dy = {{(OUT_POS_W-BYTE_W){status_q[ST_Y_SIGN]}}, b};
        nx = x_acc + dx;
        ny = y_acc + dy;
        if (dx[OUT_POS_W-1] == x_acc[OUT_POS_W-1] && nx[OUT_POS_W-1] != x_acc[OUT_POS_W-1])
          wraps++;
        if (dy[OUT_POS_W-1] == y_acc[OUT_POS_W-1] && ny[OUT_POS_W-1] != y_acc[OUT_POS_W-1])
          wraps++;
        r.pos_x = nx;
        r.pos_y = ny;
        r.left_button = status_q[ST_LEFT];
        r.right_button = status_q[ST_RIGHT];
        r.display_word = DISPLAY_BASE | {8'h00, nx[7:0], ny[7:0]};
        r.display_word[DISP_LEFT_BIT] = r.left_button;
        r.display_word[DISP_RIGHT_BIT] = r.right_button;
        expected_packets.push_back(r);
        if (r.left_button && r.right_button) begin
          nx = '0;
          ny = '0;
          clears++;
        end
        x_acc = nx;
        y_acc = ny;
        phase_q = PH_STATUS;
      end
      default: begin
        status_q = b;
        phase_q = PH_X;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase_q = PH_STATUS;
      status_q = '0;
      xmove_q = '0;
      x_acc = '0;
      y_acc = '0;
      expected_packets.delete();
    end else begin
      // compare first: an output in this cycle belongs to an earlier packet
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[M_USED_W-1:0]);
        if (expected_packets.size() == 0) begin
          fails++;
          $display("%0t: unexpected transaction: expected none, actual 0x%0h", $time, m_tdata);
        end else begin
          want = expected_packets.pop_front();
          compare_field("pos_x", DISPLAY_W'(want.pos_x), DISPLAY_W'(got.pos_x));
          compare_field("pos_y", DISPLAY_W'(want.pos_y), DISPLAY_W'(got.pos_y));
          compare_field("left_button", DISPLAY_W'(want.left_button),
                        DISPLAY_W'(got.left_button));
          compare_field("right_button", DISPLAY_W'(want.right_button),
                        DISPLAY_W'(got.right_button));
          compare_field("display_word", want.display_word, got.display_word);
          checked++;
        end
      end
      if (s_tvalid && s_tready)
        track_byte(s_tdata[BYTE_W-1:0]);
    end
    fail_count <= fails;
    pending <= expected_packets.size();
    packets_checked <= checked;
    clears_seen <= clears;
    wraps_seen <= wraps;
  end

endmodule

// ----- tb/sv/ps2_mouse_packet_tracker_tb.sv -----
module ps2_mouse_packet_tracker_tb;
  import ps2mt_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tready;
  wire                  s_tready;
  wire                  m_tvalid;
  wire  [M_TDATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int packets_checked;
  int clears_seen;
  int wraps_seen;
  int bytes_sent;
  int burst_left;
  int idle_cycles;
  int ready_mode;
  int mode_cycles;

  ps2_mouse_packet_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ps2_packet_monitor packet_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .packets_checked (packets_checked),
    .clears_seen     (clears_seen),
    .wraps_seen      (wraps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: switch to a randomly chosen stall pattern each time mode_cycles wraps
  initial begin
    ready_mode = 0;
    mode_cycles = 0;
  end

  always @(posedge clk) begin
    if (mode_cycles == 49) begin
      mode_cycles <= 0;
      ready_mode <= $urandom_range(0, 3);
    end else begin
      mode_cycles <= mode_cycles + 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (mode_cycles % 8) < 5;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] drift_move(input logic neg);
    return neg ? BYTE_W'($urandom_range(8'h00, 8'h30)) : BYTE_W'($urandom_range(8'hD0, 8'hFF));
  endfunction

  initial begin
    logic [BYTE_W-1:0] directed_bytes[$];
    logic [BYTE_W-1:0] status;
    logic              x_neg;
    logic              y_neg;

    directed_bytes = '{
      8'h00, 8'h00, 8'h00,
      8'h01, 8'h7F, 8'h01,
      8'h12, 8'hFF, 8'h80,
      8'h30, 8'h80, 8'h80,
      8'h08, 8'hFF, 8'hFF,
      8'h3C, 8'h00, 8'h00,
      8'h03, 8'h55, 8'hAA,
      8'hFF, 8'hFF, 8'hFF,
      8'hC0, 8'h01, 8'h02
    };
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    idle_cycles = 0;
    bytes_sent = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);

    // long drift without clears drives both accumulators through wrap
    x_neg = 1'($urandom_range(0, 1));
    y_neg = 1'($urandom_range(0, 1));
    for (int p = 0; p < 200; p++) begin
      status = BYTE_W'($urandom_range(0, 255));
      if (p < 150) begin
        status[ST_X_SIGN] = x_neg;
        status[ST_Y_SIGN] = y_neg;
        if (status[ST_LEFT])
          status[ST_RIGHT] = 1'b0;
        send_byte(status);
        send_byte(drift_move(x_neg));
        send_byte(drift_move(y_neg));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          status[ST_LEFT] = 1'b1;
          status[ST_RIGHT] = 1'b1;
        end
        send_byte(status);
        send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d mouse bytes; checked %0d packets for position, buttons and display.",
             bytes_sent, packets_checked);
    $display("Saw %0d both-button clears and %0d accumulator wraps.", clears_seen, wraps_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
